// ----- src/text_console_char_buffer_core_defines.svh -----
// assertion macros for the text console character buffer
`ifndef TEXT_CONSOLE_CHAR_BUFFER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_BUFFER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TCB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("tcb assertion failed");
`define TCB_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("tcb forbidden condition seen");
`else
`define TCB_ASSERT(lbl, clk, rstn, prop)
`define TCB_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- src/tcb_pkg.sv -----
// constants, types and address helper for the text console character buffer
package tcb_pkg;

  localparam int COLUMNS = 64;
  localparam int ROWS    = 32;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);

  localparam int ACTION_W   = 3;
  localparam int CHAR_W     = 8;
  localparam int RD_ROW_W   = 5;
  localparam int RD_COL_W   = 6;
  localparam int CUR_COL_W  = 6;
  localparam int CUR_ROW_W  = 5;
  localparam int HOME_COL_W = 6;
  localparam int HOME_ROW_W = 5;
  localparam int CFG_W      = 6;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HOME_COL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_ROW = CFG_IDX_W'(1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_EMIT    = 3'd0,
    ACT_NEWLINE = 3'd1,
    ACT_CLEAR   = 3'd2,
    ACT_INIT    = 3'd3,
    ACT_READ    = 3'd4
  } act_e;

  // logical row plus scroll base gives the physical row
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] base);
    logic [ROW_W:0] sum;
    sum = {1'b0, row} + {1'b0, base};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return ADDR_W'(sum[ROW_W-1:0]) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

// ----- src/tcb_ram.sv -----
// generic single write, single read ram with registered read data
module tcb_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/text_console_char_buffer_core.sv -----
// text console character store with cursor, scroll via rotating row base
// emit, newline and unused actions report via the output register, in-range reads pass the
// ram read register first; a scroll clears one row and clear or init clear every cell,
// paced by one ram write port; one item per cycle while idle and the output is free
// reset: cursor, home and row base go to zero, then a clearing pass over every cell
// zeroes the store, no item is accepted until it ends
module text_console_char_buffer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcb_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tcb_pkg::ACTION_W-1:0]   action_i,
  input  logic [tcb_pkg::CHAR_W-1:0]     char_code_i,
  input  logic [tcb_pkg::RD_ROW_W-1:0]   read_row_i,
  input  logic [tcb_pkg::RD_COL_W-1:0]   read_col_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tcb_pkg::CHAR_W-1:0]     read_data_o,
  output logic [tcb_pkg::CUR_COL_W-1:0]  cursor_col_o,
  output logic [tcb_pkg::CUR_ROW_W-1:0]  cursor_row_o,
  output logic                           scrolled_o
);
  import tcb_pkg::*;
  `include "text_console_char_buffer_core_defines.svh"

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CLEAR  = 5'b00010,
    ST_SCROLL = 5'b00100,
    ST_READ   = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   sweep_q, sweep_d;
  logic [COL_W-1:0]    cur_col_q, cur_col_d;
  logic [ROW_W-1:0]    cur_row_q, cur_row_d;
  logic [ROW_W-1:0]    base_q, base_d;
  logic                pend_q, pend_d;
  logic                scr_q, scr_d;
  logic [HOME_COL_W-1:0] home_col_q;
  logic [HOME_ROW_W-1:0] home_row_q;

  logic                out_valid_q;
  logic [CHAR_W-1:0]   out_data_q, out_data_d;
  logic [COL_W-1:0]    out_col_q;
  logic [ROW_W-1:0]    out_row_q;
  logic                out_scr_q, out_scr_d;
  logic                out_load;
  logic                out_free;

  logic                in_acc;
  act_e                act;
  logic                rd_in_range;
  logic                do_adv;
  logic [COL_W:0]      col_inc;
  logic [ROW_W:0]      row_inc;
  logic [ROW_W:0]      base_inc;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CHAR_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CHAR_W-1:0]   ram_rdata;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == ST_IDLE) && out_free);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign act         = act_e'(action_i);
  assign rd_in_range = (int'(read_row_i) < ROWS) && (int'(read_col_i) < COLUMNS);
  assign col_inc     = {1'b0, cur_col_q} + (COL_W+1)'(1);
  assign row_inc     = {1'b0, cur_row_q} + (ROW_W+1)'(1);
  assign base_inc    = {1'b0, base_q} + (ROW_W+1)'(1);
  assign ram_raddr   = cell_addr(ROW_W'(read_row_i), COL_W'(read_col_i), base_q);

  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    base_d     = base_q;
    pend_d     = pend_q;
    scr_d      = scr_q;
    ram_we     = 1'b0;
    ram_waddr  = cell_addr(cur_row_q, cur_col_q, base_q);
    ram_wdata  = char_code_i;
    ram_re     = 1'b0;
    out_load   = 1'b0;
    out_data_d = '0;
    out_scr_d  = 1'b0;
    do_adv     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          scr_d = 1'b0;
          unique case (act)
            ACT_EMIT: begin
              ram_we = (int'(cur_row_q) < ROWS) && (int'(cur_col_q) < COLUMNS - 1);
              if (col_inc >= (COL_W+1)'(COLUMNS - 1)) begin
                do_adv = 1'b1;
              end else begin
                cur_col_d = col_inc[COL_W-1:0];
                out_load  = 1'b1;
              end
            end
            ACT_NEWLINE: begin
              do_adv = 1'b1;
            end
            ACT_CLEAR: begin
              sweep_d = '0;
              pend_d  = 1'b1;
              state_d = ST_CLEAR;
            end
            ACT_INIT: begin
              cur_col_d = (int'(home_col_q) > COLUMNS - 2) ? COL_W'(COLUMNS - 2)
                                                           : COL_W'(home_col_q);
              cur_row_d = (int'(home_row_q) > ROWS - 1) ? ROW_W'(ROWS - 1)
                                                        : ROW_W'(home_row_q);
              sweep_d   = '0;
              pend_d    = 1'b1;
              state_d   = ST_CLEAR;
            end
            ACT_READ: begin
              if (rd_in_range) begin
                ram_re  = 1'b1;
                state_d = ST_READ;
              end else begin
                out_load = 1'b1;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
          if (do_adv) begin
            cur_col_d = '0;
            if (row_inc >= (ROW_W+1)'(ROWS)) begin
              cur_row_d = ROW_W'(ROWS - 1);
              scr_d     = 1'b1;
              sweep_d   = '0;
              state_d   = ST_SCROLL;
            end else begin
              cur_row_d = row_inc[ROW_W-1:0];
              out_load  = 1'b1;
            end
          end
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = '0;
        sweep_d   = sweep_q + ADDR_W'(1);
        if (sweep_q == ADDR_W'(CELLS - 1)) begin
          state_d = pend_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_SCROLL: begin
        // old top row becomes the new bottom row
        ram_we    = 1'b1;
        ram_waddr = cell_addr('0, sweep_q[COL_W-1:0], base_q);
        ram_wdata = '0;
        sweep_d   = sweep_q + ADDR_W'(1);
        if (sweep_q[COL_W-1:0] == COL_W'(COLUMNS - 1)) begin
          base_d  = (base_inc >= (ROW_W+1)'(ROWS)) ? '0 : base_inc[ROW_W-1:0];
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = ram_rdata;
          state_d    = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_scr_d = scr_q;
          pend_d    = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      base_q      <= '0;
      pend_q      <= 1'b0;
      scr_q       <= 1'b0;
      home_col_q  <= '0;
      home_row_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      base_q    <= base_d;
      pend_q    <= pend_d;
      scr_q     <= scr_d;
      if (cfg_we_i && (cfg_idx_i == CFG_HOME_COL)) begin
        home_col_q <= cfg_wdata_i[HOME_COL_W-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == CFG_HOME_ROW)) begin
        home_row_q <= cfg_wdata_i[HOME_ROW_W-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
      out_col_q  <= cur_col_d;
      out_row_q  <= cur_row_d;
      out_scr_q  <= out_scr_d;
    end
  end

  tcb_ram #(
    .Width(CHAR_W),
    .Depth(CELLS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = out_data_q;
  assign cursor_col_o = CUR_COL_W'(out_col_q);
  assign cursor_row_o = CUR_ROW_W'(out_row_q);
  assign scrolled_o   = out_scr_q;

  `TCB_NEVER(a_cursor_writable, clk_i, rst_ni, int'(cur_col_q) >= COLUMNS - 1)
  `TCB_NEVER(a_no_write_when_reporting, clk_i, rst_ni,
             ram_we && ((state_q == ST_READ) || (state_q == ST_DONE)))
  `TCB_ASSERT(a_read_goes_to_ram, clk_i, rst_ni,
              (in_acc && (act == ACT_READ) && rd_in_range) |=> (state_q == ST_READ))
  `TCB_ASSERT(a_scroll_flagged, clk_i, rst_ni, (state_q == ST_SCROLL) |-> scr_q)

endmodule

// ----- test/tb_text_console_char_buffer_core.sv -----
// self-checking testbench for the text console character buffer core
module tb_text_console_char_buffer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int          SETTLE_CYCLES = tcb_pkg::CELLS + 16;
  localparam int          PHASE_ITEMS   = 110;

  localparam logic [tcb_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [tcb_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [tcb_pkg::ACTION_W-1:0]  ACT_SPARE_FIRST = 3'd5;
  localparam logic [tcb_pkg::ACTION_W-1:0]  ACT_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [tcb_pkg::CHAR_W-1:0]    read_data;
    logic [tcb_pkg::CUR_COL_W-1:0] cursor_col;
    logic [tcb_pkg::CUR_ROW_W-1:0] cursor_row;
    logic                          scrolled;
  } console_result_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [tcb_pkg::CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [tcb_pkg::CFG_W-1:0]     cfg_wdata_i = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic [tcb_pkg::ACTION_W-1:0]  action_i    = '0;
  logic [tcb_pkg::CHAR_W-1:0]    char_code_i = '0;
  logic [tcb_pkg::RD_ROW_W-1:0]  read_row_i  = '0;
  logic [tcb_pkg::RD_COL_W-1:0]  read_col_i  = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [tcb_pkg::CHAR_W-1:0]    read_data_o;
  logic [tcb_pkg::CUR_COL_W-1:0] cursor_col_o;
  logic [tcb_pkg::CUR_ROW_W-1:0] cursor_row_o;
  logic                          scrolled_o;

  text_console_char_buffer_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .char_code_i  (char_code_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .scrolled_o   (scrolled_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // console model
  logic [tcb_pkg::CHAR_W-1:0]     screen_mem [tcb_pkg::ROWS][tcb_pkg::COLUMNS];
  logic [tcb_pkg::CUR_COL_W-1:0]  model_col;
  logic [tcb_pkg::CUR_ROW_W-1:0]  model_row;
  logic [tcb_pkg::HOME_COL_W-1:0] model_home_col;
  logic [tcb_pkg::HOME_ROW_W-1:0] model_home_row;

  console_result_t expected_q[$];
  int              mismatch_count = 0;
  int              burst_left     = 0;
  int unsigned     cycle_count    = 0;
  int              stall_mode     = 0;
  int              stall_left     = 0;

  function automatic void wipe_screen();
    for (int r = 0; r < tcb_pkg::ROWS; r++) begin
      for (int c = 0; c < tcb_pkg::COLUMNS; c++) begin
        screen_mem[r][c] = '0;
      end
    end
  endfunction

  function automatic logic next_line();
    model_col = '0;
    if (int'(model_row) == tcb_pkg::ROWS - 1) begin
      for (int r = 0; r < tcb_pkg::ROWS - 1; r++) begin
        for (int c = 0; c < tcb_pkg::COLUMNS; c++) begin
          screen_mem[r][c] = screen_mem[r+1][c];
        end
      end
      for (int c = 0; c < tcb_pkg::COLUMNS; c++) begin
        screen_mem[tcb_pkg::ROWS-1][c] = '0;
      end
      return 1'b1;
    end
    model_row = model_row + 1'b1;
    return 1'b0;
  endfunction

  function automatic console_result_t console_step(input logic [tcb_pkg::ACTION_W-1:0] act,
                                                   input logic [tcb_pkg::CHAR_W-1:0] ch,
                                                   input logic [tcb_pkg::RD_ROW_W-1:0] rr,
                                                   input logic [tcb_pkg::RD_COL_W-1:0] rc);
    console_result_t res;
    res = '0;
    case (act)
      tcb_pkg::ACT_EMIT: begin
        if (int'(model_col) < tcb_pkg::COLUMNS - 1) begin
          screen_mem[model_row][model_col] = ch;
        end
        model_col = model_col + 1'b1;
        if (int'(model_col) >= tcb_pkg::COLUMNS - 1) begin
          res.scrolled = next_line();
        end
      end
      tcb_pkg::ACT_NEWLINE: res.scrolled = next_line();
      tcb_pkg::ACT_CLEAR: wipe_screen();
      tcb_pkg::ACT_INIT: begin
        model_col = (int'(model_home_col) > tcb_pkg::COLUMNS - 2) ?
                    tcb_pkg::CUR_COL_W'(tcb_pkg::COLUMNS - 2) : model_home_col;
        model_row = (int'(model_home_row) > tcb_pkg::ROWS - 1) ?
                    tcb_pkg::CUR_ROW_W'(tcb_pkg::ROWS - 1) : model_home_row;
        wipe_screen();
      end
      tcb_pkg::ACT_READ: begin
        if (int'(rr) < tcb_pkg::ROWS && int'(rc) < tcb_pkg::COLUMNS) begin
          res.read_data = screen_mem[rr][rc];
        end
      end
      default: ;
    endcase
    res.cursor_col = model_col;
    res.cursor_row = model_row;
    return res;
  endfunction

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 150);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ~out_stall_i;
    endcase
  end

  always @(posedge clk_i) begin : check_results
    console_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: read_data %0h cursor %0d,%0d scrolled %0b",
               read_data_o, cursor_row_o, cursor_col_o, scrolled_o);
        mismatch_count++;
      end else begin
        want = expected_q.pop_front();
        if (read_data_o !== want.read_data) begin
          $error("read_data expected %0h actual %0h", want.read_data, read_data_o);
          mismatch_count++;
        end
        if (cursor_col_o !== want.cursor_col) begin
          $error("cursor_col expected %0d actual %0d", want.cursor_col, cursor_col_o);
          mismatch_count++;
        end
        if (cursor_row_o !== want.cursor_row) begin
          $error("cursor_row expected %0d actual %0d", want.cursor_row, cursor_row_o);
          mismatch_count++;
        end
        if (scrolled_o !== want.scrolled) begin
          $error("scrolled expected %0b actual %0b", want.scrolled, scrolled_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic [tcb_pkg::ACTION_W-1:0] act,
                           input logic [tcb_pkg::CHAR_W-1:0] ch,
                           input logic [tcb_pkg::RD_ROW_W-1:0] rr,
                           input logic [tcb_pkg::RD_COL_W-1:0] rc);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    action_i    <= act;
    char_code_i <= ch;
    read_row_i  <= rr;
    read_col_i  <= rc;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(console_step(act, ch, rr, rc));
  endtask

  task automatic emit_char(input logic [tcb_pkg::CHAR_W-1:0] ch);
    send_item(tcb_pkg::ACT_EMIT, ch, tcb_pkg::RD_ROW_W'($urandom), tcb_pkg::RD_COL_W'($urandom));
  endtask

  task automatic read_cell(input int rr, input int rc);
    send_item(tcb_pkg::ACT_READ, tcb_pkg::CHAR_W'($urandom), tcb_pkg::RD_ROW_W'(rr),
              tcb_pkg::RD_COL_W'(rc));
  endtask

  task automatic plain_action(input logic [tcb_pkg::ACTION_W-1:0] act);
    send_item(act, tcb_pkg::CHAR_W'($urandom), tcb_pkg::RD_ROW_W'($urandom),
              tcb_pkg::RD_COL_W'($urandom));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tcb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tcb_pkg::CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == tcb_pkg::CFG_HOME_COL) begin
      model_home_col = tcb_pkg::HOME_COL_W'(value);
    end else if (idx == tcb_pkg::CFG_HOME_ROW) begin
      model_home_row = tcb_pkg::HOME_ROW_W'(value);
    end
  endtask

  task automatic test_power_on();
    write_reg(tcb_pkg::CFG_HOME_COL, '0);
    write_reg(tcb_pkg::CFG_HOME_ROW, '0);
    read_cell(0, 0);
    read_cell(tcb_pkg::ROWS - 1, tcb_pkg::COLUMNS - 1);
    emit_char(8'hFF);
    emit_char(8'h00);
    read_cell(0, 0);
    read_cell(0, 1);
    for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++) begin
      plain_action(tcb_pkg::ACTION_W'(a));
    end
    plain_action(tcb_pkg::ACT_NEWLINE);
    read_cell(1, 0);
  endtask

  // home past the last writable column, cursor on the bottom row
  task automatic test_home_saturation();
    wait_idle();
    write_reg(tcb_pkg::CFG_HOME_COL, 6'h3F);
    write_reg(tcb_pkg::CFG_HOME_ROW, 6'h1F);
    write_reg(CFG_SPARE_A, 6'h3F);
    write_reg(CFG_SPARE_B, 6'h2A);
    plain_action(tcb_pkg::ACT_INIT);
    read_cell(tcb_pkg::ROWS - 1, tcb_pkg::COLUMNS - 2);
    emit_char(8'hA5);
    read_cell(tcb_pkg::ROWS - 2, tcb_pkg::COLUMNS - 2);
    read_cell(tcb_pkg::ROWS - 1, tcb_pkg::COLUMNS - 1);
    emit_char(8'h5A);
    plain_action(tcb_pkg::ACT_NEWLINE);
    read_cell(tcb_pkg::ROWS - 2, 0);
    plain_action(tcb_pkg::ACT_CLEAR);
    read_cell(tcb_pkg::ROWS - 3, tcb_pkg::COLUMNS - 2);
  endtask

  task automatic test_random_traffic(input int home_col, input int home_row,
                                     input int emit_pct, input int newline_pct);
    int done;
    int pick;
    int rr;
    wait_idle();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(tcb_pkg::CFG_HOME_COL, tcb_pkg::CFG_W'(home_col));
      write_reg(tcb_pkg::CFG_HOME_ROW, tcb_pkg::CFG_W'(home_row));
    end else begin
      write_reg(tcb_pkg::CFG_HOME_ROW, tcb_pkg::CFG_W'(home_row));
      write_reg(tcb_pkg::CFG_HOME_COL, tcb_pkg::CFG_W'(home_col));
    end
    write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, tcb_pkg::CFG_W'($urandom));
    plain_action(tcb_pkg::ACT_INIT);
    done = 1;
    while (done < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < emit_pct) begin
        emit_char(tcb_pkg::CHAR_W'($urandom));
      end else if (pick < emit_pct + newline_pct) begin
        plain_action(tcb_pkg::ACT_NEWLINE);
      end else if (pick < 96) begin
        if ($urandom_range(0, 1) == 0) begin
          rr = int'(model_row) - $urandom_range(0, 1);
          read_cell(rr < 0 ? 0 : rr, $urandom_range(0, tcb_pkg::COLUMNS - 1));
        end else begin
          read_cell($urandom_range(0, 31), $urandom_range(0, 63));
        end
      end else if (pick < 97) begin
        plain_action(tcb_pkg::ACT_CLEAR);
      end else if (pick < 98) begin
        plain_action(tcb_pkg::ACT_INIT);
      end else begin
        plain_action(tcb_pkg::ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)));
        done--;
      end
      done++;
    end
  endtask

  initial begin
    wipe_screen();
    model_col      = '0;
    model_row      = '0;
    model_home_col = '0;
    model_home_row = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    test_power_on();
    test_home_saturation();
    test_random_traffic(0, 0, 55, 12);
    test_random_traffic(62, 31, 75, 1);
    test_random_traffic(63, 0, 75, 1);
    test_random_traffic($urandom_range(0, 63), $urandom_range(0, 31), 55, 12);
    test_random_traffic($urandom_range(0, 63), $urandom_range(26, 31), 60, 8);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/tcb_pkg.sv
src/tcb_ram.sv
src/text_console_char_buffer_core.sv
test/tb_text_console_char_buffer_core.sv
